// File: hdl/bdq_pkg.sv
// Shared types and constants for the bounded deque with delete-by-value.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 5;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_BACK   = 2'd2,
    CMD_DELETE     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_RD,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

// File: hdl/bdq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps

module bdq_ram #(
  parameter int WIDTH = bdq_pkg::DATA_W,
  parameter int DEPTH = bdq_pkg::CAPACITY_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/bdq_addr_map.sv
// Ring address unit: maps a logical position to a physical RAM row.
`timescale 1ns / 1ps

module bdq_addr_map #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF,
  localparam int IDX_W   = $clog2(CAPACITY)
) (
  input  logic [IDX_W-1:0] base,
  input  logic [IDX_W-1:0] offset,
  output logic [IDX_W-1:0] addr
);

  logic [IDX_W:0] sum;

  // base and offset both stay below CAPACITY, so one subtract wraps the sum
  always_comb begin
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (IDX_W+1)'(CAPACITY)) begin
      sum = sum - (IDX_W+1)'(CAPACITY);
    end
    addr = sum[IDX_W-1:0];
  end

endmodule

// File: hdl/bounded_deque_with_delete.sv
// Top level of the bounded deque with push front/back, pop back and delete-by-value.
`timescale 1ns / 1ps

// Channel   Dir  Ports                    Beat contents
// --------  ---  -----------------------  ----------------------------------------
// command   in   in_tvalid/tready/tuser/  tuser: cmd; tdata: value
//                tdata
// result    out  out_tvalid/tready/tuser/ tuser: status; tdata: popped_value,
//                tdata                    entry_count
//
// Each command beat steps through the sequencer states; in_tready is low until the result is
// loaded into the output register. Push front/back go through dispatch and done, pop back
// adds a RAM read state; delete scans from the front up to the match, then closes the gap,
// one RAM read per cycle through the ring address unit.
// rst_n (synchronous, active low) empties the list; the RAM is not cleared.
// A result held by out_tready low stalls only the next command's completion.

module bounded_deque_with_delete #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // command channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bdq_pkg::CMD_W-1:0]        in_tuser,   // [1:0] cmd
  input  logic [bdq_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] value
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bdq_pkg::STATUS_W-1:0]     out_tuser,  // [1:0] status
  output logic [bdq_pkg::OUT_TDATA_W-1:0]  out_tdata   // [31:0] popped_value,
                                                       // [36:32] entry_count, [39:37] zero
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int L_W   = CNT_W + 1;
  localparam int DW    = bdq_pkg::DATA_W;
  localparam int CW    = bdq_pkg::COUNT_W;

  // sequencer and list state
  bdq_pkg::state_t  state_r,  state_nxt;
  bdq_pkg::cmd_t    cmd_r,    cmd_nxt;
  bdq_pkg::status_t status_r, status_nxt;
  logic [DW-1:0]    val_r,    val_nxt;
  logic [DW-1:0]    popped_r, popped_nxt;
  logic [IDX_W-1:0] head_r,   head_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic [IDX_W-1:0] idx_r,    idx_nxt;
  logic [IDX_W-1:0] hole_r,   hole_nxt;
  logic [IDX_W-1:0] last_r,   last_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  bdq_pkg::status_t out_status_r;
  logic [DW-1:0]    out_popped_r;
  logic [CW-1:0]    out_count_r;
  logic             out_load;

  // RAM and address unit
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [DW-1:0]    ram_wdata;
  logic             ram_re;
  logic [DW-1:0]    ram_rdata;
  logic [IDX_W-1:0] map_off;
  logic [IDX_W-1:0] map_addr;

  logic             is_full;
  logic             is_empty;
  logic [IDX_W-1:0] head_dec;
  logic [CNT_W-1:0] cnt_m1;
  logic [L_W-1:0]   idx_p1;
  logic [L_W-1:0]   idx_p2;
  logic [L_W-1:0]   cnt_ext;

  bdq_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (map_addr),
    .rdata (ram_rdata)
  );

  bdq_addr_map #(
    .CAPACITY (CAPACITY)
  ) u_map (
    .base   (head_r),
    .offset (map_off),
    .addr   (map_addr)
  );

  assign is_full  = (cnt_r == CNT_W'(CAPACITY));
  assign is_empty = (cnt_r == '0);
  assign head_dec = (head_r == '0) ? IDX_W'(CAPACITY - 1) : head_r - IDX_W'(1);
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign idx_p1   = L_W'(idx_r) + L_W'(1);
  assign idx_p2   = L_W'(idx_r) + L_W'(2);
  assign cnt_ext  = L_W'(cnt_r);

  assign in_tready = (state_r == bdq_pkg::S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    status_nxt = status_r;
    val_nxt    = val_r;
    popped_nxt = popped_r;
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    hole_nxt   = hole_r;
    last_nxt   = last_r;
    ram_we     = 1'b0;
    ram_waddr  = map_addr;
    ram_wdata  = val_r;
    ram_re     = 1'b0;
    map_off    = '0;
    out_load   = 1'b0;

    unique case (state_r)
      bdq_pkg::S_IDLE: begin
        // latch the command beat
        if (in_tvalid) begin
          cmd_nxt    = bdq_pkg::cmd_t'(in_tuser);
          val_nxt    = in_tdata[DW-1:0];
          status_nxt = bdq_pkg::ST_OK;
          popped_nxt = '0;
          idx_nxt    = '0;
          state_nxt  = bdq_pkg::S_DISPATCH;
        end
      end

      bdq_pkg::S_DISPATCH: begin
        unique case (cmd_r)
          bdq_pkg::CMD_PUSH_FRONT: begin
            // step the head back one row and write there
            if (is_full) begin
              status_nxt = bdq_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = head_dec;
              head_nxt  = head_dec;
              cnt_nxt   = cnt_r + CNT_W'(1);
            end
            state_nxt = bdq_pkg::S_DONE;
          end
          bdq_pkg::CMD_PUSH_BACK: begin
            map_off = cnt_r[IDX_W-1:0];
            if (is_full) begin
              status_nxt = bdq_pkg::ST_FULL;
            end else begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
            state_nxt = bdq_pkg::S_DONE;
          end
          bdq_pkg::CMD_POP_BACK: begin
            map_off = cnt_m1[IDX_W-1:0];
            if (is_empty) begin
              status_nxt = bdq_pkg::ST_EMPTY;
              state_nxt  = bdq_pkg::S_DONE;
            end else begin
              ram_re    = 1'b1;
              cnt_nxt   = cnt_m1;
              state_nxt = bdq_pkg::S_POP_RD;
            end
          end
          bdq_pkg::CMD_DELETE: begin
            // start the scan at the front
            if (is_empty) begin
              status_nxt = bdq_pkg::ST_NOT_FOUND;
              state_nxt  = bdq_pkg::S_DONE;
            end else begin
              ram_re    = 1'b1;
              last_nxt  = map_addr;
              state_nxt = bdq_pkg::S_SCAN;
            end
          end
          default: begin
            state_nxt = bdq_pkg::S_DONE;
          end
        endcase
      end

      bdq_pkg::S_POP_RD: begin
        popped_nxt = ram_rdata;
        state_nxt  = bdq_pkg::S_DONE;
      end

      bdq_pkg::S_SCAN: begin
        // ram_rdata holds logical entry idx_r, read from row last_r
        map_off = idx_p1[IDX_W-1:0];
        if (ram_rdata == val_r) begin
          hole_nxt = last_r;
          if (idx_p1 < cnt_ext) begin
            ram_re    = 1'b1;
            last_nxt  = map_addr;
            state_nxt = bdq_pkg::S_SHIFT;
          end else begin
            cnt_nxt   = cnt_m1;
            state_nxt = bdq_pkg::S_DONE;
          end
        end else if (idx_p1 < cnt_ext) begin
          idx_nxt  = idx_p1[IDX_W-1:0];
          ram_re   = 1'b1;
          last_nxt = map_addr;
        end else begin
          status_nxt = bdq_pkg::ST_NOT_FOUND;
          state_nxt  = bdq_pkg::S_DONE;
        end
      end

      bdq_pkg::S_SHIFT: begin
        // move entry idx_r+1 down into the hole, then advance the hole
        ram_we    = 1'b1;
        ram_waddr = hole_r;
        ram_wdata = ram_rdata;
        hole_nxt  = last_r;
        idx_nxt   = idx_p1[IDX_W-1:0];
        map_off   = idx_p2[IDX_W-1:0];
        if (idx_p2 < cnt_ext) begin
          ram_re   = 1'b1;
          last_nxt = map_addr;
        end else begin
          cnt_nxt   = cnt_m1;
          state_nxt = bdq_pkg::S_DONE;
        end
      end

      bdq_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = bdq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bdq_pkg::S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdq_pkg::S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    status_r <= status_nxt;
    val_r    <= val_nxt;
    popped_r <= popped_nxt;
    idx_r    <= idx_nxt;
    hole_r   <= hole_nxt;
    last_r   <= last_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_popped_r <= popped_r;
      out_count_r  <= CW'(cnt_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(bdq_pkg::OUT_TDATA_W - DW - CW){1'b0}}, out_count_r, out_popped_r};

  // the entry count never exceeds the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a full result always reports a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == bdq_pkg::ST_FULL) |-> out_count_r == CW'(CAPACITY))
    else $error("full status with count below capacity");

  // an empty result reports an empty list and no popped value
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == bdq_pkg::ST_EMPTY) |->
      (out_count_r == '0 && out_popped_r == '0))
    else $error("empty status with entries or popped data");

  // the RAM is written only while a command is being carried out
  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == bdq_pkg::S_DISPATCH || state_r == bdq_pkg::S_SHIFT))
    else $error("RAM write outside dispatch or shift");

endmodule
